// ===== hw/rtl/fisp_pkg.sv =====
// Shared types and constants for the firmware image section parser.
`timescale 1ns / 1ps

package fisp_pkg;

    localparam int OFFSET_WIDTH_DEF = 24;
    localparam int SKIP_BYTES_DEF   = 16;

    localparam int IMG_W   = 24;
    localparam int POS_W   = 24;
    localparam int CNT_W   = 16;
    localparam int WORDS_W = 16;
    localparam int MAGIC_W = 16;
    localparam int ENTRY_W = 32;

    // result queue depth; two slots must be free to take a byte
    localparam int RES_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_SECTION = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [MAGIC_W-1:0]  magic;
        logic [ENTRY_W-1:0]  entry;
        logic [WORDS_W-1:0]  words;
        logic [POS_W-1:0]    position;
        logic [CNT_W-1:0]    count;
        logic                last;
    } t_result;

    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage

// ===== hw/rtl/fisp_parser.sv =====
// Byte-wise image layout parser: state update and result generation per transfer.
`timescale 1ns / 1ps

module fisp_parser #(
    parameter int OFFSET_WIDTH = 24,
    parameter int SKIP_BYTES   = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_image_start,
    input  logic [fisp_pkg::IMG_W-1:0] i_image_size,
    output fisp_pkg::t_push           o_push,
    output fisp_pkg::t_result         o_res0,
    output fisp_pkg::t_result         o_res1
);
    import fisp_pkg::*;

    localparam int SKIP_W  = (SKIP_BYTES < 2) ? 1 : $clog2(SKIP_BYTES + 1);
    localparam int SKIP_CW = SKIP_W + 1;
    localparam int CMP_W   = (OFFSET_WIDTH > IMG_W) ? OFFSET_WIDTH : IMG_W;
    localparam int END_W   = OFFSET_WIDTH + WORDS_W + 2;
    localparam int REM_W   = WORDS_W + 1;
    localparam int SEC_HDR_BYTES = 6;
    localparam int SIZE_BYTES    = 2;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [6:0] {
        PH_MAGIC   = 7'b0000001,
        PH_SKIP    = 7'b0000010,
        PH_ENTRY   = 7'b0000100,
        PH_SSIZE   = 7'b0001000,
        PH_SENTRY  = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_DONE    = 7'b1000000
    } t_phase;

    t_phase                  r_phase, n_phase, c_phase;
    logic [OFFSET_WIDTH-1:0] r_off, n_off, c_off;
    logic [1:0]              r_idx, n_idx, c_idx;
    logic [31:0]             r_asm, n_asm, c_asm;
    logic [WORDS_W-1:0]      r_words, n_words, c_words;
    logic [REM_W-1:0]        r_rem, n_rem, c_rem;
    logic [CNT_W-1:0]        r_cnt, n_cnt, c_cnt;
    logic [MAGIC_W-1:0]      r_magic, n_magic, c_magic;
    logic [SKIP_W-1:0]       r_skip, n_skip, c_skip;

    logic [OFFSET_WIDTH-1:0] pos;
    logic [OFFSET_WIDTH-1:0] at;
    logic [31:0]             half_asm;
    logic [31:0]             ent_asm;
    logic [SKIP_CW-1:0]      skip_inc;
    logic [END_W-1:0]        sec_end;
    logic [REM_W-1:0]        rem_dec;
    logic                    v0, v1;
    t_result                 res0, res1;

    // entry point bytes arrive as bits 23:16, 31:24, 7:0, 15:8
    function automatic logic [31:0] entry_merge(input logic [31:0] a, input logic [1:0] k,
                                                input logic [7:0] b);
        logic [31:0] r;
        r = a;
        case (k)
            2'd0:    r[23:16] = r[23:16] | b;
            2'd1:    r[31:24] = r[31:24] | b;
            2'd2:    r[7:0]   = r[7:0] | b;
            default: r[15:8]  = r[15:8] | b;
        endcase
        return r;
    endfunction

    always_comb begin
        c_phase = r_phase;
        c_off   = r_off;
        c_idx   = r_idx;
        c_asm   = r_asm;
        c_words = r_words;
        c_rem   = r_rem;
        c_cnt   = r_cnt;
        c_magic = r_magic;
        c_skip  = r_skip;
        if (i_image_start) begin
            c_phase = PH_MAGIC;
            c_off   = '0;
            c_idx   = '0;
            c_asm   = '0;
            c_words = '0;
            c_rem   = '0;
            c_cnt   = '0;
            c_magic = '0;
            c_skip  = '0;
        end

        n_phase = c_phase;
        n_off   = c_off;
        n_idx   = c_idx;
        n_asm   = c_asm;
        n_words = c_words;
        n_rem   = c_rem;
        n_cnt   = c_cnt;
        n_magic = c_magic;
        n_skip  = c_skip;

        pos      = c_off + 1'b1;
        half_asm = c_asm | (32'(i_data_byte) << (c_idx[0] ? 8 : 0));
        ent_asm  = entry_merge(c_asm, c_idx, i_data_byte);
        skip_inc = SKIP_CW'(c_skip) + 1'b1;
        sec_end  = END_W'(pos) + END_W'({c_words, 1'b0});
        rem_dec  = (c_rem != '0) ? c_rem - 1'b1 : c_rem;
        at       = pos;

        v0   = 1'b0;
        v1   = 1'b0;
        res0 = '0;
        res1 = '0;

        if (c_phase != PH_DONE) begin
            n_off = pos;
        end

        unique case (c_phase)
            PH_MAGIC: begin
                if (c_idx[0]) begin
                    n_magic = half_asm[MAGIC_W-1:0];
                    n_asm   = '0;
                    n_idx   = '0;
                    n_phase = (SKIP_BYTES > 0) ? PH_SKIP : PH_ENTRY;
                end else begin
                    n_asm = half_asm;
                    n_idx = c_idx + 1'b1;
                end
            end
            PH_SKIP: begin
                if (skip_inc >= SKIP_CW'(SKIP_BYTES)) begin
                    n_skip  = '0;
                    n_phase = PH_ENTRY;
                end else begin
                    n_skip = skip_inc[SKIP_W-1:0];
                end
            end
            PH_ENTRY: begin
                if (c_idx == 2'd3) begin
                    v0            = 1'b1;
                    res0.kind     = KIND_HEADER;
                    res0.magic    = c_magic;
                    res0.entry    = ent_asm;
                    res0.position = POS_W'(pos);
                    res0.count    = c_cnt;
                    res0.last     = 1'b1;
                    n_asm         = '0;
                    n_idx         = '0;
                    n_phase       = PH_SSIZE;
                end else begin
                    n_asm = ent_asm;
                    n_idx = c_idx + 1'b1;
                end
            end
            PH_SSIZE: begin
                if (c_idx[0]) begin
                    n_words = half_asm[WORDS_W-1:0];
                    n_asm   = '0;
                    n_idx   = '0;
                    n_phase = PH_SENTRY;
                end else begin
                    n_asm = half_asm;
                    n_idx = c_idx + 1'b1;
                end
            end
            PH_SENTRY: begin
                if (c_idx == 2'd3) begin
                    v0    = 1'b1;
                    n_asm = '0;
                    n_idx = '0;
                    if (c_words != '0 && sec_end <= END_W'(i_image_size)) begin
                        n_cnt         = (c_cnt != CNT_MAX) ? c_cnt + 1'b1 : c_cnt;
                        res0.kind     = KIND_SECTION;
                        res0.entry    = ent_asm;
                        res0.words    = c_words;
                        res0.position = POS_W'(pos);
                        res0.count    = n_cnt;
                        res0.last     = 1'b1;
                        n_rem         = {c_words, 1'b0};
                        n_phase       = PH_PAYLOAD;
                    end else begin
                        // rejected: end lies where this section header began
                        res0.kind     = KIND_END;
                        res0.position = POS_W'(pos - OFFSET_WIDTH'(SEC_HDR_BYTES));
                        res0.count    = c_cnt;
                        res0.last     = 1'b1;
                        n_phase       = PH_DONE;
                    end
                end else begin
                    n_asm = ent_asm;
                    n_idx = c_idx + 1'b1;
                end
            end
            PH_PAYLOAD: begin
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    n_phase = PH_SSIZE;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // image ran out while a header is open or about to open
        if (c_phase != PH_DONE && n_phase != PH_PAYLOAD && n_phase != PH_DONE &&
            CMP_W'(pos) >= CMP_W'(i_image_size)) begin
            if (n_phase == PH_SSIZE) begin
                at = pos - OFFSET_WIDTH'(n_idx);
            end else if (n_phase == PH_SENTRY) begin
                at = pos - OFFSET_WIDTH'(SIZE_BYTES) - OFFSET_WIDTH'(n_idx);
            end
            n_phase = PH_DONE;
            if (v0) begin
                v1            = 1'b1;
                res0.last     = 1'b0;
                res1.kind     = KIND_END;
                res1.position = POS_W'(at);
                res1.count    = n_cnt;
                res1.last     = 1'b1;
            end else begin
                v0            = 1'b1;
                res0.kind     = KIND_END;
                res0.position = POS_W'(at);
                res0.count    = n_cnt;
                res0.last     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_off   <= '0;
            r_idx   <= '0;
            r_asm   <= '0;
            r_words <= '0;
            r_rem   <= '0;
            r_cnt   <= '0;
            r_magic <= '0;
            r_skip  <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_off   <= n_off;
            r_idx   <= n_idx;
            r_asm   <= n_asm;
            r_words <= n_words;
            r_rem   <= n_rem;
            r_cnt   <= n_cnt;
            r_magic <= n_magic;
            r_skip  <= n_skip;
        end
    end

    assign o_push.first  = i_valid & v0;
    assign o_push.second = i_valid & v1;
    assign o_res0 = res0;
    assign o_res1 = res1;

endmodule

// ===== hw/rtl/fisp_result_fifo.sv =====
// Small result queue: up to two writes and one read per cycle.
`timescale 1ns / 1ps

module fisp_result_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fisp_pkg::t_push    i_push,
    input  fisp_pkg::t_result  i_res0,
    input  fisp_pkg::t_result  i_res1,
    input  logic               i_pop,
    output logic               o_valid,
    output logic               o_stall,
    output fisp_pkg::t_result  o_res
);
    import fisp_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W_Q = $clog2(RES_DEPTH + 1);

    t_result            r_mem [RES_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W_Q-1:0] r_count, n_count;
    logic               pop;

    assign pop = i_pop & o_valid;

    always_comb begin
        n_wr    = r_wr + PTR_W'(i_push.first) + PTR_W'(i_push.second);
        n_rd    = r_rd + PTR_W'(pop);
        n_count = r_count + CNT_W_Q'(i_push.first) + CNT_W_Q'(i_push.second)
                  - CNT_W_Q'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push.second) begin
            r_mem[r_wr + 1'b1] <= i_res1;
        end
    end

    assign o_valid = (r_count != '0);
    // a byte may post two results, so keep two slots open
    assign o_stall = (r_count > CNT_W_Q'(RES_DEPTH - 2));
    assign o_res   = r_mem[r_rd];

endmodule

// ===== hw/rtl/firmware_image_section_parser.sv =====
// Top level: firmware image section parser with result queue and size register.
// Results pass through a registered queue. Throughput: one byte per cycle while not
// stalled; the final header byte can post two results, drained one per cycle while
// i_out_stall is low, from a four-entry queue that stalls input below two free slots.
// Reset (synchronous, active low): parser back to the magic word, image_size 0,
// result queue empty.
`timescale 1ns / 1ps

module firmware_image_section_parser #(
    parameter int OFFSET_WIDTH = fisp_pkg::OFFSET_WIDTH_DEF,
    parameter int SKIP_BYTES   = fisp_pkg::SKIP_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fisp_pkg::IMG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_image_start,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_result_kind,
    output logic [fisp_pkg::MAGIC_W-1:0]  o_magic_word,
    output logic [fisp_pkg::ENTRY_W-1:0]  o_entry_point,
    output logic [fisp_pkg::WORDS_W-1:0]  o_section_words,
    output logic [fisp_pkg::POS_W-1:0]    o_byte_position,
    output logic [fisp_pkg::CNT_W-1:0]    o_section_count,
    output logic                          o_last_result
);
    import fisp_pkg::*;

    logic [IMG_W-1:0] r_image_size;
    logic             in_xfer;
    t_push            push;
    t_result          res0, res1, head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= '0;
        end else if (i_cfg_we) begin
            r_image_size <= i_cfg_data;
        end
    end

    assign in_xfer = i_in_valid & ~o_in_stall;

    fisp_parser #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .SKIP_BYTES   (SKIP_BYTES)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_xfer),
        .i_data_byte   (i_data_byte),
        .i_image_start (i_image_start),
        .i_image_size  (r_image_size),
        .o_push        (push),
        .o_res0        (res0),
        .o_res1        (res1)
    );

    fisp_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_pop   (~i_out_stall),
        .o_valid (o_out_valid),
        .o_stall (o_in_stall),
        .o_res   (head)
    );

    assign o_result_kind   = head.kind;
    assign o_magic_word    = head.magic;
    assign o_entry_point   = head.entry;
    assign o_section_words = head.words;
    assign o_byte_position = head.position;
    assign o_section_count = head.count;
    assign o_last_result   = head.last;

`ifndef SYNTH
    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.second |-> push.first)
        else $error("second result pushed without first");

    a_push_needs_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.first |-> in_xfer)
        else $error("result pushed without input transfer");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_END) |-> o_last_result)
        else $error("end result not marked last");

    a_stall_means_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result queue");
`endif

endmodule
